// ===== rtl/hrsd_pkg.sv =====
// Shared types and constants for the hex record stream decoder.
`timescale 1ns / 1ps

package hrsd_pkg;

    localparam int CHAR_W   = 8;
    localparam int KIND_W   = 2;
    localparam int ADDR_W   = 32;
    localparam int HALF_W   = 16;
    localparam int UPPER_W  = 16;
    localparam int OFFSET_W = 16;
    localparam int WORD_W   = 8;
    localparam int ACC_W    = 12;
    localparam int NIB_W    = 4;

    // Result kinds as seen on the output channel
    localparam logic [KIND_W-1:0] KIND_WRITE    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EOF      = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PAGE_END = 2'd2;

    localparam logic [UPPER_W-1:0] UPPER_RESET = 16'd2048;

    // One queued operation from the parser to the output stage
    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [OFFSET_W-1:0] offset;
        logic [WORD_W-1:0]   word;
        logic [ACC_W-1:0]    acc;
        logic [NIB_W-1:0]    digit;
        logic                last;
    } hrsd_op_t;

    typedef struct packed {
        logic full;
        logic empty;
    } hrsd_queue_status_t;

endpackage

// ===== rtl/hrsd_char_if.sv =====
// Input channel: one text character per beat.
`timescale 1ns / 1ps

interface hrsd_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_char;

    modport source (output valid, output text_char, input ready);
    modport sink   (input valid, input text_char, output ready);
endinterface

// ===== rtl/hrsd_result_if.sv =====
// Output channel: one decoded result per beat.
`timescale 1ns / 1ps

interface hrsd_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] address;
    logic [15:0] halfword;
    logic        last_in_record;

    modport source (output valid, output kind, output address, output halfword,
                    output last_in_record, input ready);
    modport sink   (input valid, input kind, input address, input halfword,
                    input last_in_record, output ready);
endinterface

// ===== rtl/hrsd_front.sv =====
// Parser front end: tracks record position and fields, issues operations.
`timescale 1ns / 1ps

module hrsd_front (
    input  logic                  clk,
    input  logic                  rst_n,
    hrsd_char_if.sink             text_in,
    input  hrsd_pkg::hrsd_queue_status_t q_status,
    output logic                  push_valid,
    output hrsd_pkg::hrsd_op_t    push_op
);
    import hrsd_pkg::*;

    localparam logic [1:0] MODE_HUNT   = 2'd0;
    localparam logic [1:0] MODE_RECORD = 2'd1;
    localparam logic [1:0] MODE_SKIP   = 2'd2;

    localparam logic [1:0] REC_IGNORE = 2'd0;
    localparam logic [1:0] REC_DATA   = 2'd1;
    localparam logic [1:0] REC_EOF    = 2'd2;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_CLOSE = 8'h5D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_ALPHA = 8'd55;

    localparam logic [9:0] POS_MAX = 10'h3FF;

    logic [1:0]          mode_reg, mode_next;
    logic [7:0]          prev_reg, prev_next;
    logic [9:0]          pos_reg, pos_next;
    logic [7:0]          bcount_reg, bcount_next;
    logic [OFFSET_W-1:0] offset_reg, offset_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic [1:0]          rkind_reg, rkind_next;

    logic            accept;
    logic [7:0]      c;
    logic [NIB_W-1:0] nib;
    logic [7:0]      nib_sub;
    logic [9:0]      pos_inc;
    logic [9:0]      j;
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] words;
    logic            check_start;
    logic            emit;
    hrsd_op_t        op;

    assign text_in.ready = !q_status.full;
    assign accept        = text_in.valid && text_in.ready;
    assign c             = text_in.text_char;

    // '0'..'9' map to c-48, anything else to c-55, low nibble kept
    assign nib_sub = ((c >= CH_ZERO) && (c <= CH_NINE)) ? (c - CH_ZERO) : (c - CH_ALPHA);
    assign nib     = nib_sub[NIB_W-1:0];

    assign pos_inc = (pos_reg != POS_MAX) ? (pos_reg + 10'd1) : pos_reg;
    assign j       = pos_inc - 10'd9;
    assign word    = j[9:2];
    assign words   = {1'b0, bcount_reg[7:1]};

    always_comb
    begin
        mode_next   = mode_reg;
        prev_next   = prev_reg;
        pos_next    = pos_reg;
        bcount_next = bcount_reg;
        offset_next = offset_reg;
        acc_next    = acc_reg;
        rkind_next  = rkind_reg;
        check_start = 1'b0;
        emit        = 1'b0;
        op          = '0;
        op.kind     = KIND_WRITE;

        if (accept)
        begin
            if (c == CH_CLOSE)
            begin
                mode_next   = MODE_HUNT;
                prev_next   = 8'd0;
                pos_next    = '0;
                bcount_next = '0;
                offset_next = '0;
                acc_next    = '0;
                rkind_next  = REC_IGNORE;
                emit        = 1'b1;
                op.kind     = KIND_PAGE_END;
            end
            else
            begin
                case (mode_reg)
                    MODE_SKIP:
                    begin
                        if (c == CH_COLON)
                            mode_next = MODE_RECORD;
                    end
                    MODE_RECORD:
                    begin
                        if (c == CH_COLON)
                        begin
                            mode_next   = MODE_HUNT;
                            check_start = 1'b1;
                        end
                        else if (c == CH_PLUS)
                        begin
                            mode_next = MODE_SKIP;
                        end
                        else
                        begin
                            pos_next = pos_inc;
                            if (pos_inc == 10'd1)
                                bcount_next = {nib, 4'd0};
                            else if (pos_inc == 10'd2)
                                bcount_next = bcount_reg | {4'd0, nib};
                            else if ((pos_inc >= 10'd3) && (pos_inc <= 10'd6))
                                offset_next = {offset_reg[OFFSET_W-NIB_W-1:0], nib};
                            else if (pos_inc == 10'd8)
                            begin
                                if (c == CH_ZERO)
                                    rkind_next = REC_DATA;
                                else if (c == CH_ONE)
                                begin
                                    rkind_next = REC_EOF;
                                    emit       = 1'b1;
                                    op.kind    = KIND_EOF;
                                end
                                else
                                    rkind_next = REC_IGNORE;
                            end
                            else if ((pos_inc >= 10'd9) && (rkind_reg == REC_DATA))
                            begin
                                if (j[1:0] != 2'd3)
                                    acc_next = {acc_reg[ACC_W-NIB_W-1:0], nib};
                                else if (word < words)
                                begin
                                    acc_next  = '0;
                                    emit      = 1'b1;
                                    op.kind   = KIND_WRITE;
                                    op.offset = offset_reg;
                                    op.word   = word;
                                    op.acc    = acc_reg;
                                    op.digit  = nib;
                                    op.last   = ((word + 8'd1) == words);
                                end
                            end
                        end
                    end
                    default:
                        check_start = 1'b1;
                endcase

                if (check_start && (c == CH_COLON) && (prev_reg < CH_ZERO))
                begin
                    mode_next   = MODE_RECORD;
                    pos_next    = '0;
                    bcount_next = '0;
                    offset_next = '0;
                    acc_next    = '0;
                    rkind_next  = REC_IGNORE;
                end
                prev_next = c;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_HUNT;
            prev_reg   <= '0;
            pos_reg    <= '0;
            bcount_reg <= '0;
            offset_reg <= '0;
            acc_reg    <= '0;
            rkind_reg  <= REC_IGNORE;
        end
        else
        begin
            mode_reg   <= mode_next;
            prev_reg   <= prev_next;
            pos_reg    <= pos_next;
            bcount_reg <= bcount_next;
            offset_reg <= offset_next;
            acc_reg    <= acc_next;
            rkind_reg  <= rkind_next;
        end
    end

    assign push_valid = emit;
    assign push_op    = op;

endmodule

// ===== rtl/hrsd_queue.sv =====
// Small operation queue between parser and output stage.
`timescale 1ns / 1ps

module hrsd_queue #(
    parameter int DEPTH = 2
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  hrsd_pkg::hrsd_op_t            push_op,
    input  logic                          pop,
    output hrsd_pkg::hrsd_op_t            head_op,
    output hrsd_pkg::hrsd_queue_status_t  status
);
    import hrsd_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    hrsd_op_t         slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : (wr_ptr_reg + PTR_W'(1));
    assign rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : (rd_ptr_reg + PTR_W'(1));

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_next;
            if (pop)
                rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_op;
    end

    assign head_op      = slot_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CNT_FULL);
    assign status.empty = (count_reg == '0);

endmodule

// ===== rtl/hrsd_back.sv =====
// Output stage: forms address and byte-swapped halfword, holds the result beat.
`timescale 1ns / 1ps

module hrsd_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [15:0]                   cfg_wdata,
    input  hrsd_pkg::hrsd_op_t            head_op,
    input  hrsd_pkg::hrsd_queue_status_t  q_status,
    output logic                          pop,
    hrsd_result_if.source                 result_out
);
    import hrsd_pkg::*;

    logic [UPPER_W-1:0] upper_reg;
    logic               valid_reg;
    logic [KIND_W-1:0]  kind_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [HALF_W-1:0]  half_reg;
    logic               last_reg;

    logic               is_write;
    logic [ADDR_W-1:0]  addr_sum;
    logic [HALF_W-1:0]  half_swap;

    assign pop      = !q_status.empty && (!valid_reg || result_out.ready);
    assign is_write = (head_op.kind == KIND_WRITE);
    assign addr_sum = {upper_reg, head_op.offset}
                    + {{(ADDR_W-WORD_W-1){1'b0}}, head_op.word, 1'b0};
    // digits arrive d0 d1 d2 d3: first byte d0d1 goes low, second d2d3 high
    assign half_swap = {head_op.acc[3:0], head_op.digit, head_op.acc[11:8], head_op.acc[7:4]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_reg <= UPPER_RESET;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                upper_reg <= cfg_wdata;
            if (pop)
                valid_reg <= 1'b1;
            else if (result_out.ready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind_reg <= head_op.kind;
            addr_reg <= is_write ? addr_sum : '0;
            half_reg <= is_write ? half_swap : '0;
            last_reg <= is_write && head_op.last;
        end
    end

    assign result_out.valid          = valid_reg;
    assign result_out.kind           = kind_reg;
    assign result_out.address        = addr_reg;
    assign result_out.halfword       = half_reg;
    assign result_out.last_in_record = last_reg;

endmodule

// ===== rtl/hex_record_stream_decoder.sv =====
// Top level of the hex record stream decoder.
`timescale 1ns / 1ps

//  channel     | dir | payload                                   | beat means
//  ------------+-----+-------------------------------------------+---------------------------
//  text_in     | in  | text_char[7:0]                            | one received character
//  result_out  | out | kind, address, halfword, last_in_record   | one write / EOF / page end
//  cfg_we/wdata| in  | upper_address[15:0]                       | register write, no read
//
// One character per cycle while the queue is not full. The parser updates its record
// state in the cycle a character is taken; the result goes through a QUEUE_DEPTH-entry
// queue to a registered output stage, so it passes a queue slot and the output register
// before it shows. text_in.ready drops only while the queue is full. Asynchronous
// active-low reset puts the parser in hunting mode and sets upper_address to 0x0800;
// queue contents are not cleared, only its pointers and count.

module hex_record_stream_decoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                  clk,
    input  logic                  rst_n,
    hrsd_char_if.sink             text_in,
    hrsd_result_if.source         result_out,
    input  logic                  cfg_we,
    input  logic [15:0]           cfg_wdata
);
    import hrsd_pkg::*;

    logic               push_valid;
    hrsd_op_t           push_op;
    hrsd_op_t           head_op;
    hrsd_queue_status_t q_status;
    logic               pop;

    // Parser: classifies each character, emits at most one op per beat
    hrsd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_in    (text_in),
        .q_status   (q_status),
        .push_valid (push_valid),
        .push_op    (push_op)
    );

    // Decouples parser from downstream stalls
    hrsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push_valid),
        .push_op (push_op),
        .pop     (pop),
        .head_op (head_op),
        .status  (q_status)
    );

    // Address add, byte swap, output register and upper_address register
    hrsd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .head_op    (head_op),
        .q_status   (q_status),
        .pop        (pop),
        .result_out (result_out)
    );

    // The parser must never push into a full queue
    assert property (@(posedge clk) disable iff (!rst_n)
        !(push_valid && q_status.full))
        else $error("push into full queue");

    // The output stage must never pull from an empty queue
    assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && q_status.empty))
        else $error("pop from empty queue");

    // Non-write results carry zero address, data and last flag
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_out.valid && (result_out.kind != KIND_WRITE)) |->
        ((result_out.address == '0) && (result_out.halfword == '0)
         && !result_out.last_in_record))
        else $error("non-write result with payload");

endmodule

// ===== tb/testbench.sv =====
// Self-checking bench for the hex record stream decoder: directed table, then random pages.
`timescale 1ns / 1ps

module testbench;
    import hrsd_pkg::*;

    localparam realtime CLK_HALF = 6.0;
    localparam int RESET_CYCLES  = 8;
    localparam int STALL_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 16;
    localparam int PHASE_CHARS   = 16;
    localparam int PHASES        = 6;
    localparam int HOLD_CYCLES   = 80;
    localparam int LONG_DIGITS   = 1030;

    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_CLOSE   = 8'h5D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_ONE     = 8'h31;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] LETTER_BIAS = 8'd55;
    localparam logic [9:0] POS_LIMIT  = 10'd1023;

    typedef enum logic [1:0] {SCAN_HUNT, SCAN_RECORD, SCAN_SKIP} scan_mode_e;
    typedef enum logic [1:0] {REC_IGNORE, REC_DATA, REC_EOF} rec_kind_e;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ADDR_W-1:0] address;
        logic [HALF_W-1:0] halfword;
        logic              last_in_record;
    } result_t;

    typedef struct packed {
        logic [CHAR_W-1:0] chr;
        logic              typed;
        result_t           want;
    } stim_row_t;

    localparam result_t PAGE_END_RESULT = {KIND_PAGE_END, 32'd0, 16'd0, 1'b0};
    localparam result_t EOF_RESULT      = {KIND_EOF, 32'd0, 16'd0, 1'b0};
    // first directed write: reset upper half, offset FFFF, bytes AB CD swapped
    localparam result_t FIRST_WRITE     = {KIND_WRITE, UPPER_RESET, 16'hFFFF, 16'hCDAB, 1'b1};

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [UPPER_W-1:0] cfg_wdata;

    hrsd_char_if   char_bus();
    hrsd_result_if result_bus();

    hex_record_stream_decoder uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_in    (char_bus),
        .result_out (result_bus),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata)
    );

    always #(CLK_HALF) clk = ~clk;

    // decoder model state
    scan_mode_e         scan_mode;
    logic [7:0]         last_char;
    logic [9:0]         rec_pos;
    logic [7:0]         rec_bytes;
    logic [15:0]        rec_offset;
    logic [11:0]        digit_buf;
    rec_kind_e          rec_kind;
    logic [UPPER_W-1:0] upper_addr;

    result_t    expected_results[$];
    stim_row_t  directed[$];
    logic [7:0] page_chars[$];
    logic [7:0] record_text[$];

    int send_idle_pct;
    int recv_idle_pct;
    int hold_asked;
    int hold_done;
    int hold_left;
    int quiet_cycles;
    int failures;
    int phase_chars;

    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        logic [7:0] v;
        if (c >= CH_ZERO && c <= CH_NINE)
            v = c - CH_ZERO;
        else
            v = c - LETTER_BIAS;
        return v[3:0];
    endfunction

    task automatic clear_record_state();
        rec_pos    = '0;
        rec_bytes  = '0;
        rec_offset = '0;
        digit_buf  = '0;
        rec_kind   = REC_IGNORE;
    endtask

    // one character at a record position; EOF at type 1, writes on 4th data digits in count
    task automatic step_record(input logic [7:0] c, output bit got, output result_t r);
        logic [3:0] d;
        int j;
        int word;
        int words;
        got = 1'b0;
        r = '0;
        d = nibble_of(c);
        if (rec_pos != POS_LIMIT)
            rec_pos = rec_pos + 10'd1;
        if (rec_pos == 10'd1)
            rec_bytes = {d, 4'h0};
        else if (rec_pos == 10'd2)
            rec_bytes = rec_bytes | {4'h0, d};
        else if (rec_pos >= 10'd3 && rec_pos <= 10'd6)
            rec_offset = {rec_offset[11:0], d};
        else if (rec_pos == 10'd8)
        begin
            if (c == CH_ZERO)
                rec_kind = REC_DATA;
            else if (c == CH_ONE)
            begin
                rec_kind = REC_EOF;
                got = 1'b1;
                r.kind = KIND_EOF;
            end
            else
                rec_kind = REC_IGNORE;
        end
        else if (rec_pos >= 10'd9 && rec_kind == REC_DATA)
        begin
            j = int'(rec_pos) - 9;
            word = j / 4;
            words = int'(rec_bytes) / 2;
            if (j % 4 != 3)
                digit_buf = {digit_buf[7:0], d};
            else if (word < words)
            begin
                got = 1'b1;
                r.kind = KIND_WRITE;
                r.halfword = {digit_buf[3:0], d, digit_buf[11:8], digit_buf[7:4]};
                r.address = {upper_addr, rec_offset} + (word * 2);
                r.last_in_record = (word + 1 == words);
                digit_buf = '0;
            end
        end
    endtask

    task automatic decode_char(input logic [7:0] c, output bit got, output result_t r);
        bit check_start;
        got = 1'b0;
        r = '0;
        check_start = 1'b0;
        if (c == CH_CLOSE)
        begin
            // page end wipes all parse state, including the previous character
            scan_mode = SCAN_HUNT;
            last_char = '0;
            clear_record_state();
            got = 1'b1;
            r = PAGE_END_RESULT;
        end
        else
        begin
            case (scan_mode)
                SCAN_SKIP:
                begin
                    if (c == CH_COLON)
                        scan_mode = SCAN_RECORD;
                end
                SCAN_RECORD:
                begin
                    if (c == CH_COLON)
                    begin
                        scan_mode = SCAN_HUNT;
                        check_start = 1'b1;
                    end
                    else if (c == CH_PLUS)
                        scan_mode = SCAN_SKIP;
                    else
                        step_record(c, got, r);
                end
                default:
                    check_start = 1'b1;
            endcase
            if (check_start && c == CH_COLON && last_char < CH_ZERO)
            begin
                scan_mode = SCAN_RECORD;
                clear_record_state();
            end
            last_char = c;
        end
    endtask

    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        if (n < 4'd10)
            return CH_ZERO + n;
        else if ($urandom_range(3) == 0)
            return CH_LOWER_A + n - 8'd10;
        else
            return CH_UPPER_A + n - 8'd10;
    endfunction

    function automatic logic [7:0] stray_char();
        logic [7:0] c;
        c = 8'($urandom);
        while (c == CH_COLON || c == CH_PLUS || c == CH_CLOSE)
            c = 8'($urandom);
        return c;
    endfunction

    task automatic push_hex(input logic [15:0] v, input int digits);
        for (int i = digits - 1; i >= 0; i--)
            record_text.push_back(hex_digit(v[4*i +: 4]));
    endtask

    // mostly well-formed records with random content; some broken on purpose
    task automatic add_record();
        int r;
        int n;
        int count;
        int cut;
        int hdr_at;
        bit use_hdr;
        logic [15:0] offs;
        record_text.delete();
        r = $urandom_range(99);
        n = $urandom_range(99);
        if (n < 70)
            count = $urandom_range(8);
        else if (n < 97)
            count = $urandom_range(40, 9);
        else
            count = 255;
        if (r >= 70 && r < 85 && $urandom_range(4) != 0)
            count = 0;
        n = $urandom_range(9);
        if (n == 0)
            offs = 16'hFFFF - 16'($urandom_range(6));
        else if (n == 1)
            offs = 16'($urandom_range(3));
        else
            offs = 16'($urandom);
        push_hex(16'(count), 2);
        push_hex(offs, 4);
        record_text.push_back(hex_digit(4'($urandom)));
        if (r < 70)
            record_text.push_back(CH_ZERO);
        else if (r < 85)
            record_text.push_back(CH_ONE);
        else if (r < 95)
            record_text.push_back(hex_digit(4'($urandom_range(15, 2))));
        else
            record_text.push_back(stray_char());
        for (int i = 0; i < 2 * count; i++)
        begin
            if ($urandom_range(99) < 4)
                record_text.push_back(stray_char());
            else
                record_text.push_back(hex_digit(4'($urandom)));
        end
        if ($urandom_range(99) < 15)
            repeat ($urandom_range(8, 1)) record_text.push_back(hex_digit(4'($urandom)));
        push_hex(16'($urandom), 2);

        cut = record_text.size();
        if ($urandom_range(99) < 8)
            cut = $urandom_range(record_text.size());
        use_hdr = ($urandom_range(99) < 15);
        hdr_at = $urandom_range(cut);

        // separator ahead of the colon; a few leave a character that blocks the start
        n = $urandom_range(99);
        if (n < 40)
        begin
            page_chars.push_back(CH_CR);
            page_chars.push_back(CH_LF);
        end
        else if (n < 65)
            page_chars.push_back(CH_LF);
        else if (n < 80)
            page_chars.push_back(CH_SPACE);
        else if (n < 90)
            page_chars.push_back(8'($urandom_range(8'h2F)));
        else if (n < 95)
            page_chars.push_back(stray_char());
        page_chars.push_back(CH_COLON);
        for (int i = 0; i <= cut; i++)
        begin
            if (use_hdr && i == hdr_at)
            begin
                page_chars.push_back(CH_PLUS);
                repeat ($urandom_range(6)) page_chars.push_back(stray_char());
                page_chars.push_back(CH_COLON);
            end
            if (i < cut)
                page_chars.push_back(record_text[i]);
        end
    endtask

    task automatic build_page();
        page_chars.delete();
        repeat ($urandom_range(5, 1))
        begin
            if ($urandom_range(99) < 5)
                repeat ($urandom_range(3, 1)) page_chars.push_back(8'($urandom));
            add_record();
        end
        page_chars.push_back(CH_CLOSE);
    endtask

    // record well past the position limit
    task automatic build_long_page();
        page_chars.delete();
        page_chars.push_back(CH_LF);
        page_chars.push_back(CH_COLON);
        page_chars.push_back(CH_UPPER_A + 8'd5);
        page_chars.push_back(CH_UPPER_A + 8'd5);
        repeat (4) page_chars.push_back(hex_digit(4'($urandom)));
        page_chars.push_back(CH_ZERO);
        page_chars.push_back(CH_ZERO);
        repeat (LONG_DIGITS) page_chars.push_back(hex_digit(4'($urandom)));
        page_chars.push_back(CH_CLOSE);
    endtask

    task automatic add_row(input logic [7:0] c, input logic typed, input result_t want);
        stim_row_t row;
        row.chr = c;
        row.typed = typed;
        row.want = want;
        directed.push_back(row);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_row(s[i], 1'b0, '0);
    endtask

    task automatic send_char(input logic [7:0] c, input logic typed, input result_t want);
        bit got;
        result_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            char_bus.valid <= 1'b0;
            @(posedge clk);
        end
        char_bus.valid     <= 1'b1;
        char_bus.text_char <= c;
        @(posedge clk);
        while (!char_bus.ready)
            @(posedge clk);
        decode_char(c, got, predicted);
        if (typed)
            expected_results.push_back(want);
        else if (got)
            expected_results.push_back(predicted);
        phase_chars++;
    endtask

    task automatic send_page();
        foreach (page_chars[i])
            send_char(page_chars[i], 1'b0, '0);
    endtask

    // register write only once the pipe has drained
    task automatic drain_and_configure(input logic [UPPER_W-1:0] value);
        char_bus.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we     <= 1'b0;
        upper_addr = value;
    endtask

    task automatic check_result();
        result_t want;
        if (expected_results.size() == 0)
        begin
            $error("unexpected result: kind %0d address %h halfword %h last %0d",
                   result_bus.kind, result_bus.address, result_bus.halfword,
                   result_bus.last_in_record);
            failures++;
        end
        else
        begin
            want = expected_results.pop_front();
            if (result_bus.kind !== want.kind)
            begin
                $error("kind: expected %0d, got %0d", want.kind, result_bus.kind);
                failures++;
            end
            if (result_bus.address !== want.address)
            begin
                $error("address: expected %h, got %h", want.address, result_bus.address);
                failures++;
            end
            if (result_bus.halfword !== want.halfword)
            begin
                $error("halfword: expected %h, got %h", want.halfword, result_bus.halfword);
                failures++;
            end
            if (result_bus.last_in_record !== want.last_in_record)
            begin
                $error("last_in_record: expected %0d, got %0d",
                       want.last_in_record, result_bus.last_in_record);
                failures++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_bus.valid && result_bus.ready)
            check_result();
    end

    // watchdog on beats in either direction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((char_bus.valid && char_bus.ready) || (result_bus.valid && result_bus.ready))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= STALL_LIMIT)
                begin
                    $display("Some tests failed");
                    $finish;
                end
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    initial
    begin
        result_bus.ready = 1'b0;
        hold_done = 0;
        hold_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_done != hold_asked)
            begin
                hold_done++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_bus.ready <= 1'b0;
            end
            else
                result_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        logic [UPPER_W-1:0] setting;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_wdata          = '0;
        char_bus.valid     = 1'b0;
        char_bus.text_char = '0;
        failures     = 0;
        quiet_cycles = 0;
        hold_asked   = 0;
        phase_chars  = 0;
        send_idle_pct = 31;
        recv_idle_pct = 66;

        scan_mode  = SCAN_HUNT;
        last_char  = '0;
        upper_addr = UPPER_RESET;
        clear_record_state();

        // start, page end, cut record, link header, end of file, field extremes
        add_row(8'h00, 1'b0, '0);
        add_row(CH_CLOSE, 1'b1, PAGE_END_RESULT);
        add_text(":02FFFF00AB+h:C");
        add_row(CH_UPPER_A + 8'd3, 1'b1, FIRST_WRITE);
        add_row(8'hFF, 1'b0, '0);
        add_text(": :0000000");
        add_row(CH_ONE, 1'b1, EOF_RESULT);
        add_row(CH_CLOSE, 1'b1, PAGE_END_RESULT);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_char(directed[i].chr, directed[i].typed, directed[i].want);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: setting = 16'hFFFF;
                1: setting = 16'h0000;
                3: setting = UPPER_RESET;
                5: setting = 16'hFFFF;
                default: setting = 16'($urandom);
            endcase
            if (phase < 2)
            begin
                send_idle_pct = 31;
                recv_idle_pct = 66;
            end
            else if (phase < 4)
            begin
                send_idle_pct = 66;
                recv_idle_pct = 31;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            drain_and_configure(setting);
            phase_chars = 0;
            // output held off while the sender keeps going, so the queue backs up
            if (phase == 4)
            begin
                hold_asked++;
                build_long_page();
                send_page();
            end
            while (phase_chars < PHASE_CHARS)
            begin
                build_page();
                send_page();
            end
        end

        char_bus.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
